FILE: rtl/core/diff_drive_motor_pwm_watchdog_defines.svh
// Assertion macros used by the checker of the motor mixer block.
`ifndef DIFF_DRIVE_MOTOR_PWM_WATCHDOG_DEFINES_SVH
`define DIFF_DRIVE_MOTOR_PWM_WATCHDOG_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDMPW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DDMPW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ddmpw_pkg.sv
// Types, constants and the wheel drive function of the motor mixer block.
`timescale 1ns / 1ps

package ddmpw_pkg;

    // Register map indexes (byte address is four times the index).
    localparam logic [1:0] REG_HALF_TRACK    = 2'd0;
    localparam logic [1:0] REG_INV_MAX_SPEED = 2'd1;
    localparam logic [1:0] REG_DEADBAND      = 2'd2;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

    // Register reset values.
    localparam logic [15:0] HALF_TRACK_RST    = 16'd6554;
    localparam logic [15:0] INV_MAX_SPEED_RST = 16'd914;
    localparam logic [12:0] DEADBAND_RST      = 13'd205;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;

    // Shared multiplier operand selection.
    localparam logic [1:0] MSEL_TURN  = 2'd0;
    localparam logic [1:0] MSEL_LEFT  = 2'd1;
    localparam logic [1:0] MSEL_RIGHT = 2'd2;

    // Full-scale normalized speed in Q1.12.
    localparam logic [12:0] ONE_Q12 = 13'd4096;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       ld_in;
        logic [1:0] msel;
        logic       ld_prod;
        logic       ld_sum;
        logic       fin_left;
        logic       fin_right;
        logic       tick_commit;
        logic       out_load;
    } ddmpw_cmd_t;

    // Forward and reverse duty of one wheel.
    typedef struct packed {
        logic [7:0] fwd;
        logic [7:0] rev;
    } ddmpw_wheel_t;

    // Turns a scaled speed product (Q4.12 speed times Q8.8 gain) into duties:
    // floor shift by 8, clamp to one, deadband test, then magnitude * 255 >> 12.
    function automatic ddmpw_wheel_t wheel_drive(input logic signed [34:0] prod,
                                                 input logic [12:0] deadband);
        logic signed [26:0] n;
        logic [12:0]        mag;
        logic [20:0]        scaled;
        ddmpw_wheel_t       w;
        n = prod[34:8];
        if (n > 27'sd4096)
        begin
            mag = ONE_Q12;
        end
        else if (n < -27'sd4096)
        begin
            mag = ONE_Q12;
        end
        else if (n < 27'sd0)
        begin
            mag = 13'(-n);
        end
        else
        begin
            mag = 13'(n);
        end
        scaled = {mag, 8'd0} - {8'd0, mag};
        w.fwd = 8'd0;
        w.rev = 8'd0;
        if (mag > deadband)
        begin
            if (n > 27'sd0)
            begin
                w.fwd = scaled[19:12];
            end
            else
            begin
                w.rev = scaled[19:12];
            end
        end
        return w;
    endfunction

endpackage

FILE: rtl/core/diff_drive_motor_pwm_watchdog.sv
// A command is taken in IDLE and passes through MULP (turn product), SUMS (wheel speeds),
// MULL and MULR (wheel products) and FINR, which loads its result once the output register
// is free; a tick passes through TICK alone. No new request is taken until IDLE returns;
// the command path runs three products through one shared 18x17 multiplier.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n, asynchronous, active low) restores the register defaults, clears the
// tick counter and all duties, and empties the output register.
`timescale 1ns / 1ps

module diff_drive_motor_pwm_watchdog
    import ddmpw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // linear_speed [15:0], turn_rate [31:16]
    input  logic        s_tuser,   // opcode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // left_fwd_duty [7:0], left_rev_duty [15:8],
                                   // right_fwd_duty [23:16], right_rev_duty [31:24],
                                   // cmd_active [32], zero [39:33]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ddmpw_cmd_t cmd;

    assign pready = 1'b1;

    // Sequencer.
    ddmpw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Arithmetic, state and register file.
    ddmpw_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata)
    );

endmodule

FILE: rtl/core/ddmpw_ctrl.sv
// Sequencing state machine of the motor mixer block.
`timescale 1ns / 1ps

module ddmpw_ctrl
    import ddmpw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_tuser,
    output logic       m_tvalid,
    input  logic       m_tready,
    output ddmpw_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MULP = 3'd1;
    localparam logic [2:0] ST_SUMS = 3'd2;
    localparam logic [2:0] ST_MULL = 3'd3;
    localparam logic [2:0] ST_MULR = 3'd4;
    localparam logic [2:0] ST_FINR = 3'd5;
    localparam logic [2:0] ST_TICK = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output slot can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.msel   = MSEL_TURN;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.ld_in  = 1'b1;
                    state_next = s_tuser ? ST_TICK : ST_MULP;
                end
            end
            ST_MULP:
            begin
                cmd.msel    = MSEL_TURN;
                cmd.ld_prod = 1'b1;
                state_next  = ST_SUMS;
            end
            ST_SUMS:
            begin
                cmd.ld_sum = 1'b1;
                state_next = ST_MULL;
            end
            ST_MULL:
            begin
                cmd.msel    = MSEL_LEFT;
                cmd.ld_prod = 1'b1;
                state_next  = ST_MULR;
            end
            ST_MULR:
            begin
                cmd.msel     = MSEL_RIGHT;
                cmd.ld_prod  = 1'b1;
                cmd.fin_left = 1'b1;
                state_next   = ST_FINR;
            end
            ST_FINR:
            begin
                if (out_free)
                begin
                    cmd.fin_right = 1'b1;
                    cmd.out_load  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (out_free)
                begin
                    cmd.tick_commit = 1'b1;
                    cmd.out_load    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag follows loads and drains.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/core/ddmpw_dp.sv
// Datapath of the motor mixer block: registers, shared multiplier, duties, watchdog.
`timescale 1ns / 1ps

module ddmpw_dp
    import ddmpw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ddmpw_cmd_t  cmd,
    input  logic [31:0] s_tdata,
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata
);

    logic [15:0]        half_track_reg;
    logic [15:0]        inv_max_speed_reg;
    logic [12:0]        deadband_reg;
    logic [15:0]        timeout_ticks_reg;
    logic               cfg_wr;

    logic signed [15:0] lin_reg;
    logic signed [15:0] ang_reg;
    logic signed [17:0] vl_reg;
    logic signed [17:0] vr_reg;
    logic signed [17:0] vl_next;
    logic signed [17:0] vr_next;
    logic signed [16:0] p_turn;
    logic signed [34:0] prod_reg;
    logic signed [34:0] prod_next;
    logic signed [17:0] mul_a;
    logic signed [16:0] mul_b;

    logic [7:0]         duty_reg [4];
    logic [7:0]         duty_next [4];
    logic [16:0]        ticks_reg;
    logic [16:0]        ticks_next;
    logic               active_next;
    logic [39:0]        out_reg;
    ddmpw_wheel_t       wheel;

    // Register writes complete on the access cycle.
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_track_reg    <= HALF_TRACK_RST;
            inv_max_speed_reg <= INV_MAX_SPEED_RST;
            deadband_reg      <= DEADBAND_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_HALF_TRACK:    half_track_reg    <= pwdata[15:0];
                REG_INV_MAX_SPEED: inv_max_speed_reg <= pwdata[15:0];
                REG_DEADBAND:      deadband_reg      <= pwdata[12:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (paddr[3:2])
            REG_HALF_TRACK:    prdata = {16'd0, half_track_reg};
            REG_INV_MAX_SPEED: prdata = {16'd0, inv_max_speed_reg};
            REG_DEADBAND:      prdata = {19'd0, deadband_reg};
            REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Shared multiplier: turn rate by half track, then each wheel speed by the gain.
    always_comb
    begin
        case (cmd.msel)
            MSEL_LEFT:
            begin
                mul_a = vl_reg;
                mul_b = $signed({1'b0, inv_max_speed_reg});
            end
            MSEL_RIGHT:
            begin
                mul_a = vr_reg;
                mul_b = $signed({1'b0, inv_max_speed_reg});
            end
            default:
            begin
                mul_a = {{2{ang_reg[15]}}, ang_reg};
                mul_b = $signed({1'b0, half_track_reg});
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Wheel speeds from the turn product floored to Q4.12.
    assign p_turn  = prod_reg[32:16];
    assign vl_next = {{2{lin_reg[15]}}, lin_reg} - {p_turn[16], p_turn};
    assign vr_next = {{2{lin_reg[15]}}, lin_reg} + {p_turn[16], p_turn};

    assign wheel = wheel_drive(prod_reg, deadband_reg);

    // Duty and watchdog state update.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            duty_next[i] = duty_reg[i];
        end
        ticks_next = ticks_reg;
        if (cmd.fin_left)
        begin
            duty_next[0] = wheel.fwd;
            duty_next[1] = wheel.rev;
        end
        if (cmd.fin_right)
        begin
            duty_next[2] = wheel.fwd;
            duty_next[3] = wheel.rev;
            ticks_next   = 17'd0;
        end
        if (cmd.tick_commit)
        begin
            if (!(&ticks_reg))
            begin
                ticks_next = ticks_reg + 17'd1;
            end
            if (ticks_next > {1'b0, timeout_ticks_reg})
            begin
                for (int i = 0; i < 4; i++)
                begin
                    duty_next[i] = 8'd0;
                end
            end
        end
        active_next = (ticks_next <= {1'b0, timeout_ticks_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= 17'd0;
            for (int i = 0; i < 4; i++)
            begin
                duty_reg[i] <= 8'd0;
            end
        end
        else
        begin
            ticks_reg <= ticks_next;
            for (int i = 0; i < 4; i++)
            begin
                duty_reg[i] <= duty_next[i];
            end
        end
    end

    // Payload registers: request capture, products, wheel speeds, result.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            lin_reg <= s_tdata[15:0];
            ang_reg <= s_tdata[31:16];
        end
        if (cmd.ld_prod)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.ld_sum)
        begin
            vl_reg <= vl_next;
            vr_reg <= vr_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= {7'd0, active_next, duty_next[3], duty_next[2],
                        duty_next[1], duty_next[0]};
        end
    end

    assign m_tdata = out_reg;

endmodule

FILE: rtl/core/ddmpw_checker.sv
// Port-level checks of the motor mixer block and their binding to the top level.
`timescale 1ns / 1ps
`include "diff_drive_motor_pwm_watchdog_defines.svh"

module ddmpw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled result stays offered and unchanged.
    `DDMPW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // A wheel is never driven forward and in reverse at once.
    `DDMPW_ASSERT_NOW(a_left_excl, m_tvalid, m_tdata[7:0] == 8'd0 || m_tdata[15:8] == 8'd0, "left wheel driven both ways")

    `DDMPW_ASSERT_NOW(a_right_excl, m_tvalid, m_tdata[23:16] == 8'd0 || m_tdata[31:24] == 8'd0, "right wheel driven both ways")

    // A timed-out watchdog leaves both motors stopped.
    `DDMPW_ASSERT_NOW(a_timeout_stop, m_tvalid && !m_tdata[32], m_tdata[31:0] == 32'd0, "motors driven after timeout")

endmodule

bind diff_drive_motor_pwm_watchdog ddmpw_checker u_ddmpw_checker (.*);

FILE: dv/diff_drive_motor_pwm_watchdog_tb.sv
// Self-checking stream testbench of the wheel mixer with PWM duties and command watchdog.
`timescale 1ns / 1ps

module diff_drive_motor_pwm_watchdog_tb;
    import ddmpw_pkg::*;

    // Request kinds carried on s_tuser.
    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // The tick counter stops here instead of wrapping.
    localparam logic [16:0] TICK_SAT = 17'h1FFFF;

    // One request: kind, forward speed and yaw rate.
    typedef struct packed {
        logic               op;
        logic signed [15:0] lin;
        logic signed [15:0] turn;
    } motion_req_t;

    // Duties of both wheels and the watchdog flag.
    typedef struct packed {
        logic [7:0] lfwd;
        logic [7:0] lrev;
        logic [7:0] rfwd;
        logic [7:0] rrev;
        logic       active;
    } duty_set_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;
    logic        s_tuser = OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Register copies and state of the mixer as it should be.
    logic [15:0] cfg_half = HALF_TRACK_RST;
    logic [15:0] cfg_inv = INV_MAX_SPEED_RST;
    logic [12:0] cfg_deadband = DEADBAND_RST;
    logic [15:0] cfg_timeout = TIMEOUT_TICKS_RST;
    logic [16:0] tick_count = 17'd0;
    duty_set_t   duty_state = '0;
    longint      turn_part;

    motion_req_t motion_req_q[$];
    duty_set_t   duty_q[$];
    motion_req_t cur_req;
    duty_set_t   got_duty;
    duty_set_t   want_duty;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          no_idle = 1'b0;
    int          err_count = 0;

    diff_drive_motor_pwm_watchdog u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    // Scales one wheel speed, applies clamp and deadband; returns {fwd, rev}.
    function automatic logic [15:0] wheel_duty(input longint v);
        longint     n;
        longint     mag;
        logic [7:0] d;
        n = (v * longint'(cfg_inv)) >>> 8;
        if (n > 4096)
        begin
            n = 4096;
        end
        if (n < -4096)
        begin
            n = -4096;
        end
        mag = (n < 0) ? -n : n;
        d = 8'((mag * 255) >>> 12);
        if (mag > longint'(cfg_deadband))
        begin
            return (n > 0) ? {d, 8'd0} : {8'd0, d};
        end
        return 16'd0;
    endfunction

    // Wait for one side before its next transfer.
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        err_count++;
    endtask

    task automatic push_req(input logic op, input int lin, input int turn);
        motion_req_t r;
        r.op = op;
        r.lin = 16'(lin);
        r.turn = 16'(turn);
        motion_req_q.push_back(r);
    endtask

    // Blocks until every request is taken and every duty set has come back.
    task automatic wait_drained();
        while (motion_req_q.size() != 0 || s_tvalid || duty_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // Register write with setup and access phases, then the local copy follows.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HALF_TRACK:    cfg_half = value[15:0];
            REG_INV_MAX_SPEED: cfg_inv = value[15:0];
            REG_DEADBAND:      cfg_deadband = value[12:0];
            REG_TIMEOUT_TICKS: cfg_timeout = value[15:0];
            default:           ;
        endcase
    endtask

    // Request driver: predicts duties on each accepted request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (cur_req.op == OP_TICK)
                begin
                    if (tick_count != TICK_SAT)
                    begin
                        tick_count = tick_count + 17'd1;
                    end
                end
                else
                begin
                    turn_part = (longint'(cur_req.turn) * longint'(cfg_half)) >>> 16;
                    {duty_state.lfwd, duty_state.lrev} =
                        wheel_duty(longint'(cur_req.lin) - turn_part);
                    {duty_state.rfwd, duty_state.rrev} =
                        wheel_duty(longint'(cur_req.lin) + turn_part);
                    tick_count = 17'd0;
                end
                // Watchdog runs after every request.
                if (tick_count > {1'b0, cfg_timeout})
                begin
                    duty_state.lfwd = 8'd0;
                    duty_state.lrev = 8'd0;
                    duty_state.rfwd = 8'd0;
                    duty_state.rrev = 8'd0;
                end
                duty_state.active = (tick_count <= {1'b0, cfg_timeout});
                duty_q.push_back(duty_state);
                gap_left = draw_wait();
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (motion_req_q.size() != 0)
                begin
                    cur_req = motion_req_q.pop_front();
                    s_tdata <= {cur_req.turn, cur_req.lin};
                    s_tuser <= cur_req.op;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_duty = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24],
                            m_tdata[32]};
                if (duty_q.size() == 0)
                begin
                    report_mismatch("unexpected result", m_tdata[31:0], 0);
                end
                else
                begin
                    want_duty = duty_q.pop_front();
                    if (got_duty.lfwd != want_duty.lfwd)
                    begin
                        report_mismatch("left_fwd_duty", got_duty.lfwd, want_duty.lfwd);
                    end
                    if (got_duty.lrev != want_duty.lrev)
                    begin
                        report_mismatch("left_rev_duty", got_duty.lrev, want_duty.lrev);
                    end
                    if (got_duty.rfwd != want_duty.rfwd)
                    begin
                        report_mismatch("right_fwd_duty", got_duty.rfwd, want_duty.rfwd);
                    end
                    if (got_duty.rrev != want_duty.rrev)
                    begin
                        report_mismatch("right_rev_duty", got_duty.rrev, want_duty.rrev);
                    end
                    if (got_duty.active != want_duty.active)
                    begin
                        report_mismatch("cmd_active", got_duty.active, want_duty.active);
                    end
                end
                stall_left = draw_wait();
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus: directed cases, a back-to-back watchdog run, then random phases.
    initial
    begin
        int tick_pct;
        int lin;
        int turn;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes of both speeds and the edge of the default deadband.
        push_req(OP_CMD, 0, 0);
        push_req(OP_CMD, 32767, 0);
        push_req(OP_CMD, -32768, 0);
        push_req(OP_CMD, 0, 32767);
        push_req(OP_CMD, 0, -32768);
        push_req(OP_CMD, 32767, -32768);
        push_req(OP_CMD, -32768, 32767);
        push_req(OP_CMD, 57, 0);
        push_req(OP_CMD, 58, 0);
        push_req(OP_CMD, -58, 0);
        push_req(OP_TICK, 0, 0);
        wait_drained();

        // Watchdog expiry, then a raised and a lowered timeout.
        reg_write(REG_TIMEOUT_TICKS, 32'd1);
        push_req(OP_CMD, 4096, 0);
        push_req(OP_TICK, -1, -1);
        push_req(OP_TICK, 0, 0);
        wait_drained();
        reg_write(REG_TIMEOUT_TICKS, 32'd3);
        push_req(OP_TICK, 0, 0);
        push_req(OP_CMD, 4096, 100);
        wait_drained();
        reg_write(REG_TIMEOUT_TICKS, 32'd0);
        push_req(OP_TICK, 0, 0);
        push_req(OP_CMD, 2000, -300);
        wait_drained();

        // A deadband at full scale and a zero gain keep both motors off.
        reg_write(REG_TIMEOUT_TICKS, 32'd65535);
        reg_write(REG_DEADBAND, 32'd4096);
        push_req(OP_CMD, 32767, 32767);
        wait_drained();
        reg_write(REG_DEADBAND, 32'd0);
        reg_write(REG_INV_MAX_SPEED, 32'd0);
        push_req(OP_CMD, -32768, 1234);
        wait_drained();

        // Largest gain and track: tiny speeds and the floor of a negative turn product.
        reg_write(REG_INV_MAX_SPEED, 32'd65535);
        reg_write(REG_HALF_TRACK, 32'd65535);
        push_req(OP_CMD, 1, 0);
        push_req(OP_CMD, -1, 0);
        push_req(OP_CMD, 0, -1);
        push_req(OP_CMD, 0, 1);
        wait_drained();
        reg_write(REG_HALF_TRACK, 32'd0);
        push_req(OP_CMD, 1000, 32767);
        wait_drained();

        // Back-to-back ticks run past a short timeout and stop both motors.
        reg_write(REG_HALF_TRACK, {16'd0, HALF_TRACK_RST});
        reg_write(REG_INV_MAX_SPEED, {16'd0, INV_MAX_SPEED_RST});
        reg_write(REG_DEADBAND, {19'd0, DEADBAND_RST});
        reg_write(REG_TIMEOUT_TICKS, 32'd8);
        no_idle = 1'b1;
        push_req(OP_CMD, 3000, 500);
        for (int i = 0; i < 12; i++)
        begin
            push_req(OP_TICK, $urandom_range(0, 65535), $urandom_range(0, 65535));
        end
        wait_drained();
        reg_write(REG_TIMEOUT_TICKS, 32'd65535);
        push_req(OP_TICK, 0, 0);
        push_req(OP_CMD, -3000, 500);
        wait_drained();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 5; phase++)
        begin
            no_idle = (phase == 2);
            case ($urandom_range(0, 3))
                0:       reg_write(REG_HALF_TRACK, 32'd0);
                1:       reg_write(REG_HALF_TRACK, 32'd65535);
                default: reg_write(REG_HALF_TRACK, $urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 5))
                0:       reg_write(REG_INV_MAX_SPEED, 32'd0);
                1:       reg_write(REG_INV_MAX_SPEED, 32'd65535);
                2:       reg_write(REG_INV_MAX_SPEED, {16'd0, INV_MAX_SPEED_RST});
                default: reg_write(REG_INV_MAX_SPEED, $urandom_range(0, 4000));
            endcase
            case ($urandom_range(0, 4))
                0:       reg_write(REG_DEADBAND, 32'd0);
                1:       reg_write(REG_DEADBAND, 32'd4096);
                default: reg_write(REG_DEADBAND, $urandom_range(0, 600));
            endcase
            case ($urandom_range(0, 3))
                0:       reg_write(REG_TIMEOUT_TICKS, 32'd0);
                1:       reg_write(REG_TIMEOUT_TICKS, 32'd65535);
                default: reg_write(REG_TIMEOUT_TICKS, $urandom_range(0, 20));
            endcase
            tick_pct = $urandom_range(10, 60);
            for (int i = 0; i < 100; i++)
            begin
                // Half the speeds span the full range, half a narrow range around zero.
                if ($urandom_range(0, 1) == 0)
                begin
                    lin = $urandom_range(0, 65535);
                    turn = $urandom_range(0, 65535);
                end
                else
                begin
                    lin = int'($urandom_range(0, 6000)) - 3000;
                    turn = int'($urandom_range(0, 6000)) - 3000;
                end
                if ($urandom_range(0, 99) < tick_pct)
                begin
                    push_req(OP_TICK, lin, turn);
                end
                else
                begin
                    push_req(OP_CMD, lin, turn);
                end
            end
            wait_drained();
        end

        wait_drained();
        if (duty_q.size() != 0)
        begin
            report_mismatch("missing results", 0, duty_q.size());
        end
        if (err_count == 0)
        begin
            $display("PASS diff_drive_motor_pwm_watchdog");
        end
        else
        begin
            $display("FAIL diff_drive_motor_pwm_watchdog");
        end
        $finish;
    end

    // Run limit.
    initial
    begin
        #40_000_000;
        $display("FAIL diff_drive_motor_pwm_watchdog");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ddmpw_pkg.sv
rtl/core/ddmpw_ctrl.sv
rtl/core/ddmpw_dp.sv
rtl/core/diff_drive_motor_pwm_watchdog.sv
rtl/core/ddmpw_checker.sv
dv/diff_drive_motor_pwm_watchdog_tb.sv
